/* hdl/tcgw_pkg.sv */
// Shared types, constants and the 6x8 font for the text cursor glyph writer.
package tcgw_pkg;

    localparam int TEXT_COLUMNS    = 21;
    localparam int TEXT_ROWS       = 8;
    localparam int PANEL_WIDTH     = 128;
    localparam int PANEL_HEIGHT    = 64;
    localparam int VERTICAL_OFFSET = 16;

    localparam int GLYPH_W     = 6;
    localparam int GLYPH_COUNT = 95;
    localparam int COL_W       = 5;
    localparam int ROW_W       = 3;
    localparam int ADDR_W      = 10;
    localparam int GIDX_W      = 7;
    localparam int CNT_W       = 3;

    localparam logic [7:0] FIRST_CODE = 8'h20;
    localparam logic [7:0] LAST_CODE  = 8'h7E;
    localparam logic [7:0] NEWLINE    = 8'h0A;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_SET  = 2'd1,
        OP_HOME = 2'd2
    } opcode_t;

    // One glyph to draw: font entry, address of its first column, column count.
    typedef struct packed {
        logic [GIDX_W-1:0] glyph;
        logic [ADDR_W-1:0] base_addr;
        logic [CNT_W-1:0]  count;
    } glyph_job_t;

    // Each entry packs six column bytes, column 0 in the lowest byte.
    localparam logic [47:0] FONT_ROM [GLYPH_COUNT] = '{
        48'h000000000000, 48'h0000005F0000, 48'h000007000700, 48'h00147F147F14,
        48'h00122A7F2A24, 48'h006264081323, 48'h005022554936, 48'h000000030500,
        48'h000041221C00, 48'h00001C224100, 48'h00082A1C2A08, 48'h0008083E0808,
        48'h000000305000, 48'h000808080808, 48'h000000606000, 48'h000204081020,
        48'h003E4549513E, 48'h0000407F4200, 48'h004649516142, 48'h00314B454121,
        48'h00107F121418, 48'h003945454527, 48'h003049494A3C, 48'h000305097101,
        48'h003649494936, 48'h001E29494906, 48'h000000363600, 48'h000000365600,
        48'h004122140800, 48'h001414141414, 48'h000008142241, 48'h000609510102,
        48'h003E41794932, 48'h007E1111117E, 48'h00364949497F, 48'h00224141413E,
        48'h001C2241417F, 48'h00414949497F, 48'h00010109097F, 48'h00325141413E,
        48'h007F0808087F, 48'h0000417F4100, 48'h00013F414020, 48'h00412214087F,
        48'h00404040407F, 48'h007F0204027F, 48'h007F1008047F, 48'h003E4141413E,
        48'h00060909097F, 48'h005E2151413E, 48'h00462919097F, 48'h003149494946,
        48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F, 48'h003F4038403F,
        48'h006314081463, 48'h000304780403, 48'h004345495161, 48'h0041417F0000,
        48'h002010080402, 48'h0000007F4141, 48'h000402010204, 48'h004040404040,
        48'h000004020100, 48'h007854545420, 48'h00384444487F, 48'h002044444438,
        48'h007F48444438, 48'h001854545438, 48'h000201097E08, 48'h003C54541408,
        48'h00780404087F, 48'h0000407D4400, 48'h00003D444020, 48'h004428107F00,
        48'h0000407F4100, 48'h00780418047C, 48'h00780404087C, 48'h003844444438,
        48'h00081414147C, 48'h007C18141408, 48'h00080404087C, 48'h002054545448,
        48'h002040443F04, 48'h007C2040403C, 48'h001C2040201C, 48'h003C4030403C,
        48'h004428102844, 48'h003C5050500C, 48'h00444C546444, 48'h000041360800,
        48'h0000007F0000, 48'h000008364100, 48'h00081C2A0808
    };

endpackage

/* hdl/tcgw_front.sv */
// Command front end: holds the text cursor and turns put-character commands into glyph jobs.
module tcgw_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [tcgw_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                      q_full,
    output logic                      q_push,
    output tcgw_pkg::glyph_job_t      q_job
);
    import tcgw_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    opcode_t          op;
    logic [7:0]       code;
    logic [7:0]       set_col;
    logic [7:0]       set_row;
    logic             accept;
    logic             wrap;
    logic [ROW_W-1:0] row_inc;
    logic [COL_W-1:0] draw_col;
    logic [ROW_W-1:0] draw_row;
    logic [6:0]       top;
    logic             visible;
    logic [7:0]       base_x;
    logic [7:0]       room;
    logic [CNT_W-1:0] count;
    logic [10:0]      base_addr;
    logic [GIDX_W-1:0] glyph;

    assign op      = opcode_t'(s_tdata[1:0]);
    assign code    = s_tdata[9:2];
    assign set_col = s_tdata[17:10];
    assign set_row = s_tdata[25:18];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // Next row, held at the last row.
    assign row_inc = ({1'b0, row_reg} + 4'd1 >= 4'(TEXT_ROWS)) ? ROW_W'(TEXT_ROWS - 1)
                                                               : row_reg + ROW_W'(1);

    assign wrap     = col_reg >= COL_W'(TEXT_COLUMNS);
    assign draw_col = wrap ? '0 : col_reg;
    assign draw_row = wrap ? row_inc : row_reg;

    assign top     = 7'({draw_row, 3'b000}) + 7'(VERTICAL_OFFSET);
    assign visible = top < 7'(PANEL_HEIGHT);
    assign base_x  = 8'(draw_col * GLYPH_W);
    assign room    = 8'(PANEL_WIDTH) - base_x;

    always_comb begin
        if (!visible || base_x >= 8'(PANEL_WIDTH)) begin
            count = '0;
        end else if (room >= 8'(GLYPH_W)) begin
            count = CNT_W'(GLYPH_W);
        end else begin
            count = room[CNT_W-1:0];
        end
    end

    assign base_addr = {3'b000, base_x} + 11'(top[6:3] * PANEL_WIDTH);
    assign glyph     = (code >= FIRST_CODE && code <= LAST_CODE)
                       ? GIDX_W'(code - FIRST_CODE) : '0;

    assign q_job.glyph     = glyph;
    assign q_job.base_addr = base_addr[ADDR_W-1:0];
    assign q_job.count     = count;
    assign q_push = accept && op == OP_PUT && code != NEWLINE && count != '0;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            unique case (op)
                OP_PUT: begin
                    if (code == NEWLINE) begin
                        col_next = '0;
                        row_next = row_inc;
                    end else begin
                        col_next = draw_col + COL_W'(1);
                        row_next = draw_row;
                    end
                end
                OP_SET: begin
                    col_next = (set_col >= 8'(TEXT_COLUMNS)) ? COL_W'(TEXT_COLUMNS - 1)
                                                             : set_col[COL_W-1:0];
                    row_next = (set_row >= 8'(TEXT_ROWS)) ? ROW_W'(TEXT_ROWS - 1)
                                                          : set_row[ROW_W-1:0];
                end
                OP_HOME: begin
                    col_next = '0;
                    row_next = '0;
                end
                default: begin
                    col_next = col_reg;
                    row_next = row_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* hdl/tcgw_queue.sv */
// Two-entry job queue between the command front end and the column writer.
module tcgw_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tcgw_pkg::glyph_job_t push_job,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output tcgw_pkg::glyph_job_t head_job
);
    import tcgw_pkg::*;

    glyph_job_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = cnt_reg == 2'd2;
    assign valid    = cnt_reg != 2'd0;
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hdl/tcgw_back.sv */
// Column writer: walks the glyph columns and drives the framebuffer write stream.
module tcgw_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  tcgw_pkg::glyph_job_t q_job,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [tcgw_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);
    import tcgw_pkg::*;

    glyph_job_t       job_reg;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic             valid_reg, valid_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]       data_reg;
    logic             last_reg;

    logic             can_emit;
    logic             emit;
    logic             last_col;

    assign can_emit = !valid_reg || m_tready;
    assign emit     = busy_reg && can_emit;
    assign last_col = col_reg == job_reg.count - CNT_W'(1);
    assign q_pop    = q_valid && (!busy_reg || (emit && last_col));

    always_comb begin
        busy_next = busy_reg;
        col_next  = col_reg;
        if (q_pop) begin
            busy_next = 1'b1;
            col_next  = '0;
        end else if (emit) begin
            busy_next = !last_col;
            col_next  = col_reg + CNT_W'(1);
        end
        valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            col_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            col_reg   <= col_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
        if (emit) begin
            addr_reg <= job_reg.base_addr + ADDR_W'(col_reg);
            data_reg <= FONT_ROM[job_reg.glyph][{col_reg, 3'b000} +: 8];
            last_reg <= last_col;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b000000, data_reg, addr_reg};
    assign m_tlast  = last_reg;

endmodule

/* hdl/text_cursor_glyph_writer.sv */
// Top level of the text cursor glyph writer: front end, job queue and column writer.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata) takes text commands: put a
//   character, set the cursor (clamped to the text grid) or home it. A
//   transfer takes place when tvalid and tready are both high at a rising edge.
//   The master channel (m_tvalid/m_tready/m_tdata/m_tlast) gives framebuffer
//   byte writes, one per visible glyph column, m_tlast on the final one.
//   Job path: the first write of a glyph passes the queue, the job register
//   of the column writer and then its output register.
//   Writes: a drawn glyph gives up to six writes, one per visible column, on
//   the single output port; cursor commands, newlines and fully clipped
//   glyphs give no writes. Commands are taken while the column writer works,
//   until its two-entry job queue fills.
//   Reset (aresetn low, synchronous) homes the cursor, empties the queue and
//   drops any write in flight.
//   When the receiver stalls, the output register holds its write, the
//   column writer waits, and the slave side keeps taking commands until the
//   queue is full, then drops s_tready.
module text_cursor_glyph_writer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // opcode[1:0], char_code[9:2], cursor_col[17:10],
                                   // cursor_row[25:18], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // fb_address[9:0], fb_data[17:10], zero fill
    output logic        m_tlast    // last write of this character
);
    import tcgw_pkg::*;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    glyph_job_t push_job;
    glyph_job_t head_job;

    // Classify commands and keep the cursor; hand drawable glyphs on.
    tcgw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    // Decouple the two sides so each stalls on its own.
    tcgw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_job (head_job)
    );

    // Emit one font column per cycle through the output register while the receiver takes them.
    tcgw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // No write is offered straight after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("write offered after reset");

    // Only an accepted put-character command queues a glyph.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (s_tvalid && s_tready && s_tdata[1:0] == OP_PUT))
        else $error("glyph queued without a put-character transfer");

    // The column writer never takes a job from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid)
        else $error("job taken from empty queue");

    // A queued job always has at least one column to write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (push_job.count != '0 && push_job.count <= CNT_W'(GLYPH_W)))
        else $error("queued job with bad column count");

endmodule
